@@ src/btw_pkg.sv @@
package btw_pkg;

    // Coordinate format.
    localparam int CW = 32;
    localparam int FB = 16;
    localparam int NUM_COORDS = 12;

    // Edge vector, dot product term and dot product sum widths.
    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int DW = PW + 2;

    // Split of a dot product into a signed high and an unsigned low half.
    localparam int HW = DW / 2;
    localparam int LW = 2 * HW + 2;

    // Gram products, determinant and numerators.
    localparam int GW = 2 * DW;
    localparam int NW = GW + 1;

    // Threshold register width.
    localparam int TW = 63;

    // Division: quotient bits below the saturation point, remainder width.
    localparam int QB = CW - 1;
    localparam int RW = NW + QB;

    typedef struct packed {
        logic signed [DW-1:0] d00;
        logic signed [DW-1:0] d01;
        logic signed [DW-1:0] d11;
        logic signed [DW-1:0] d20;
        logic signed [DW-1:0] d21;
    } t_dots;

    typedef struct packed {
        logic          deg;
        logic          neg_b;
        logic          neg_c;
        logic [NW-1:0] mag_det;
        logic [NW-1:0] mag_b;
        logic [NW-1:0] mag_c;
    } t_gram;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] q;
        logic          ovf;
        logic          neg;
    } t_lane;

    typedef struct packed {
        logic          deg;
        logic [NW-1:0] det;
        t_lane [1:0]   lane;
    } t_divst;

endpackage

@@ src/btw_dot.sv @@
module btw_dot import btw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [NUM_COORDS*CW-1:0] i_coords,
    output logic                     o_valid,
    output t_dots                    o_dots
);

    logic signed [EW-1:0] r_e0 [3];
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [EW-1:0] n_e0 [3];
    logic signed [EW-1:0] n_e1 [3];
    logic signed [EW-1:0] n_e2 [3];

    logic signed [PW-1:0] r_p00 [3];
    logic signed [PW-1:0] r_p01 [3];
    logic signed [PW-1:0] r_p11 [3];
    logic signed [PW-1:0] r_p20 [3];
    logic signed [PW-1:0] r_p21 [3];

    t_dots r_dots;
    logic  r_v1;
    logic  r_v2;
    logic  r_v3;

    // Edge vectors C-A, B-A and P-A, one bit wider than the coordinates.
    always_comb begin
        logic [CW-1:0] p, a, b, c;
        for (int i = 0; i < 3; i++) begin
            p = i_coords[i*CW +: CW];
            a = i_coords[(3+i)*CW +: CW];
            b = i_coords[(6+i)*CW +: CW];
            c = i_coords[(9+i)*CW +: CW];
            n_e0[i] = $signed({c[CW-1], c}) - $signed({a[CW-1], a});
            n_e1[i] = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
            n_e2[i] = $signed({p[CW-1], p}) - $signed({a[CW-1], a});
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Edge stage, product stage and sum stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e0[i]  <= n_e0[i];
                r_e1[i]  <= n_e1[i];
                r_e2[i]  <= n_e2[i];
                r_p00[i] <= r_e0[i] * r_e0[i];
                r_p01[i] <= r_e0[i] * r_e1[i];
                r_p11[i] <= r_e1[i] * r_e1[i];
                r_p20[i] <= r_e2[i] * r_e0[i];
                r_p21[i] <= r_e2[i] * r_e1[i];
            end
            r_dots.d00 <= DW'(r_p00[0]) + DW'(r_p00[1]) + DW'(r_p00[2]);
            r_dots.d01 <= DW'(r_p01[0]) + DW'(r_p01[1]) + DW'(r_p01[2]);
            r_dots.d11 <= DW'(r_p11[0]) + DW'(r_p11[1]) + DW'(r_p11[2]);
            r_dots.d20 <= DW'(r_p20[0]) + DW'(r_p20[1]) + DW'(r_p20[2]);
            r_dots.d21 <= DW'(r_p21[0]) + DW'(r_p21[1]) + DW'(r_p21[2]);
        end
    end

    assign o_valid = r_v3;
    assign o_dots  = r_dots;

endmodule

@@ src/btw_gram.sv @@
module btw_gram import btw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_dots         i_dots,
    input  logic [TW-1:0] i_thr,
    output logic          o_valid,
    output t_gram         o_gram
);

    logic signed [DW-1:0] x [6];
    logic signed [DW-1:0] y [6];

    logic signed [LW-1:0] r_ll [6];
    logic signed [LW-1:0] r_lh [6];
    logic signed [LW-1:0] r_hl [6];
    logic signed [LW-1:0] r_hh [6];
    logic signed [GW-1:0] r_prod [6];
    logic signed [NW-1:0] r_det;
    logic signed [NW-1:0] r_nb;
    logic signed [NW-1:0] r_nc;
    t_gram                r_gram;
    t_gram                n_gram;
    logic                 r_v4, r_v5, r_v6, r_v7;

    // Operand pairs of the six wide products.
    always_comb begin
        x[0] = i_dots.d00;  y[0] = i_dots.d11;
        x[1] = i_dots.d01;  y[1] = i_dots.d01;
        x[2] = i_dots.d00;  y[2] = i_dots.d21;
        x[3] = i_dots.d01;  y[3] = i_dots.d20;
        x[4] = i_dots.d11;  y[4] = i_dots.d20;
        x[5] = i_dots.d01;  y[5] = i_dots.d21;
    end

    // Magnitudes, signs and the degenerate test.
    always_comb begin
        n_gram.neg_b   = r_nb[NW-1] ^ r_det[NW-1];
        n_gram.neg_c   = r_nc[NW-1] ^ r_det[NW-1];
        n_gram.mag_det = r_det[NW-1] ? NW'(-r_det) : NW'(r_det);
        n_gram.mag_b   = r_nb[NW-1] ? NW'(-r_nb) : NW'(r_nb);
        n_gram.mag_c   = r_nc[NW-1] ? NW'(-r_nc) : NW'(r_nc);
        n_gram.deg     = (r_det == '0) ||
                         (n_gram.mag_det < (NW'(i_thr) << (2 * FB)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // Partial products, recombination, differences, magnitudes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                r_ll[i] <= $signed({1'b0, x[i][HW-1:0]}) * $signed({1'b0, y[i][HW-1:0]});
                r_lh[i] <= $signed({1'b0, x[i][HW-1:0]}) * $signed(y[i][DW-1:HW]);
                r_hl[i] <= $signed(x[i][DW-1:HW]) * $signed({1'b0, y[i][HW-1:0]});
                r_hh[i] <= $signed(x[i][DW-1:HW]) * $signed(y[i][DW-1:HW]);
                r_prod[i] <= (GW'(r_hh[i]) <<< (2 * HW)) +
                             ((GW'(r_hl[i]) + GW'(r_lh[i])) <<< HW) + GW'(r_ll[i]);
            end
            r_det  <= NW'(r_prod[0]) - NW'(r_prod[1]);
            r_nb   <= NW'(r_prod[2]) - NW'(r_prod[3]);
            r_nc   <= NW'(r_prod[4]) - NW'(r_prod[5]);
            r_gram <= n_gram;
        end
    end

    assign o_valid = r_v7;
    assign o_gram  = r_gram;

endmodule

@@ src/btw_div.sv @@
module btw_div import btw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_gram         i_gram,
    output logic          o_valid,
    output logic [CW-1:0] o_weight_b,
    output logic [CW-1:0] o_weight_c,
    output logic          o_deg
);

    t_divst r_st [QB+1];
    t_divst n_st [QB+1];
    logic   r_v  [QB+1];

    // Stage 0 checks for saturation; stage s then settles quotient bit QB-s.
    always_comb begin
        logic [NW-1:0] mag [2];
        logic [RW-1:0] sub;
        mag[0] = i_gram.mag_b;
        mag[1] = i_gram.mag_c;
        n_st[0].deg = i_gram.deg;
        n_st[0].det = i_gram.mag_det;
        for (int l = 0; l < 2; l++) begin
            n_st[0].lane[l].rem = RW'(mag[l]) << FB;
            n_st[0].lane[l].q   = '0;
            n_st[0].lane[l].ovf = (RW'(mag[l]) << FB) >= (RW'(i_gram.mag_det) << QB);
            n_st[0].lane[l].neg = (l == 0) ? i_gram.neg_b : i_gram.neg_c;
        end
        for (int s = 1; s <= QB; s++) begin
            n_st[s] = r_st[s-1];
            sub = RW'(r_st[s-1].det) << (QB - s);
            for (int l = 0; l < 2; l++) begin
                if (r_st[s-1].lane[l].rem >= sub) begin
                    n_st[s].lane[l].rem      = r_st[s-1].lane[l].rem - sub;
                    n_st[s].lane[l].q[QB-s]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= QB; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s <= QB; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // Sign, saturation and the degenerate override.
    always_comb begin
        logic [CW-1:0] w [2];
        t_lane         ln;
        for (int l = 0; l < 2; l++) begin
            ln = r_st[QB].lane[l];
            if (r_st[QB].deg) begin
                w[l] = '0;
            end else if (ln.ovf) begin
                w[l] = ln.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end else begin
                w[l] = ln.neg ? CW'(-{1'b0, ln.q}) : {1'b0, ln.q};
            end
        end
        o_weight_b = w[0];
        o_weight_c = w[1];
    end

    assign o_deg   = r_st[QB].deg;
    assign o_valid = r_v[QB];

endmodule

@@ src/triangle_barycentric_weights_unit.sv @@
// Channel  | Direction | Beat contents
// s_axis   | in        | tdata: point x/y/z, corner A x/y/z, B x/y/z, C x/y/z (32 b each)
// m_axis   | out       | tdata: weight_b, weight_c (32 b each); tuser: degenerate
// cfg      | in        | i_cfg_data: degenerate threshold (63 b)
//
// One beat enters per cycle unless the output stalls; a result passes through 3 dot product
// stages, 4 Gram stages, 32 divider stages and the output register.
// The divider is a 32-stage restoring pipeline: a saturation check, then one
// quotient bit per stage.
// Reset clears all valid bits and sets the threshold to 1.
// The whole pipeline holds while a result waits at the output and m_axis_tready is low.
module triangle_barycentric_weights_unit import btw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // point_x, point_y, point_z, corner_a_x..z, corner_b_x..z, corner_c_x..z
    input  logic [NUM_COORDS*CW-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // weight_b, weight_c
    output logic [2*CW-1:0]          m_axis_tdata,
    // degenerate
    output logic                     m_axis_tuser,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [TW-1:0]            i_cfg_data
);

    logic          en;
    logic [TW-1:0] r_thr;
    logic          dot_valid, gram_valid, div_valid, div_deg;
    t_dots         dots;
    t_gram         gram;
    logic [CW-1:0] weight_b, weight_c;
    logic          r_out_valid;
    logic [2*CW-1:0] r_out_data;
    logic          r_out_deg;

    // The pipeline moves whenever the output register is free or being drained.
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= TW'(1);
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    btw_dot u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_coords (s_axis_tdata),
        .o_valid  (dot_valid),
        .o_dots   (dots)
    );

    btw_gram u_gram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dot_valid),
        .i_dots  (dots),
        .i_thr   (r_thr),
        .o_valid (gram_valid),
        .o_gram  (gram)
    );

    btw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (gram_valid),
        .i_gram     (gram),
        .o_valid    (div_valid),
        .o_weight_b (weight_b),
        .o_weight_c (weight_c),
        .o_deg      (div_deg)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {weight_c, weight_b};
            r_out_deg  <= div_deg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_deg;

endmodule
